@@ rtl/kot_pkg.sv @@
// Shared types and constants for the keyed ordered entry table.
package kot_pkg;

	localparam int DEPTH = 128;
	localparam int KEY_BITS = 22;
	localparam int KEY_FIELD_W = 22;
	localparam int CODE_W = 2;
	localparam int OP_W = 2;
	localparam int OUT_W = 8;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 2'd0,
		OP_UPDATE = 2'd1,
		OP_REMOVE = 2'd2,
		OP_FIND   = 2'd3
	} op_t;

	localparam logic [CODE_W-1:0] CODE_RUNNING = 2'd0;

	typedef struct packed {
		logic                append;
		logic                shift;
		logic                set_code;
		logic [KEY_BITS-1:0] key;
		logic [CODE_W-1:0]   code;
	} cell_ctrl_t;

endpackage

@@ rtl/kot_req_if.sv @@
// Request channel: operation, key and new status with valid/ready.
interface kot_req_if;
	logic                                valid;
	logic                                ready;
	logic [kot_pkg::OP_W-1:0]            operation;
	logic [kot_pkg::KEY_FIELD_W-1:0]     key;
	logic [kot_pkg::CODE_W-1:0]          new_status;

	modport source (output valid, operation, key, new_status, input ready);
	modport sink (input valid, operation, key, new_status, output ready);
endinterface

@@ rtl/kot_rsp_if.sv @@
// Response channel: lookup result and entry count with valid/ready.
interface kot_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [kot_pkg::CODE_W-1:0]    entry_status;
	logic [kot_pkg::OUT_W-1:0]     position;
	logic [kot_pkg::OUT_W-1:0]     entry_count;
	logic                          add_dropped;

	modport source (output valid, hit, entry_status, position, entry_count, add_dropped,
		input ready);
	modport sink (input valid, hit, entry_status, position, entry_count, add_dropped,
		output ready);
endinterface

@@ rtl/kot_cell.sv @@
// One table slot: holds a key and status, compares, appends, updates, shifts down.
module kot_cell (
	input  logic                             clk,
	input  logic [kot_pkg::KEY_BITS-1:0]     cmp_key,
	input  logic                             occupied,
	input  kot_pkg::cell_ctrl_t              ctrl,
	input  logic [kot_pkg::KEY_BITS-1:0]     next_key,
	input  logic [kot_pkg::CODE_W-1:0]       next_code,
	output logic [kot_pkg::KEY_BITS-1:0]     key,
	output logic [kot_pkg::CODE_W-1:0]       code,
	output logic                             match
);

	logic [kot_pkg::KEY_BITS-1:0] key_q;
	logic [kot_pkg::CODE_W-1:0]   code_q;

	always_ff @(posedge clk) begin
		if (ctrl.append) begin
			key_q  <= ctrl.key;
			code_q <= ctrl.code;
		end else if (ctrl.shift) begin
			key_q  <= next_key;
			code_q <= next_code;
		end else if (ctrl.set_code) begin
			code_q <= ctrl.code;
		end
	end

	assign key   = key_q;
	assign code  = code_q;
	assign match = occupied && (key_q == cmp_key);

endmodule

@@ rtl/keyed_ordered_entry_table_top.sv @@
// Top level of the keyed ordered entry table: cell row, first-match logic, control.
//
// Usage:
//   req carries one request (operation, key, new_status); rsp returns exactly one
//   response per request: hit, entry_status, position, entry_count, add_dropped.
//   Both channels move a request when valid and ready are high at a rising edge.
//   The accepted request and its match vector are registered; while busy_q is set,
//   the result is written into the output register that drives rsp.valid.
//   No new request is taken while one is in process. In the accept cycle every cell
//   compares its key with the incoming key and the match vector is registered;
//   then, with busy_q set, the first match is isolated by one wide subtract, and the
//   cells append, update or shift down toward the front in a single step.
//   A waiting response sits in an output register; the next request is taken once no
//   request is in process and that register is empty or being drained in the same
//   cycle, so a stalled receiver holds off new requests without losing anything.
//   Reset (arst_n low) empties the table and clears the busy flag and rsp.valid;
//   entry storage itself is not cleared, only the entry count.
module keyed_ordered_entry_table_top (
	input  logic     clk,
	input  logic     arst_n,
	kot_req_if.sink  req,
	kot_rsp_if.source rsp
);

	localparam int N = kot_pkg::DEPTH;

	logic [kot_pkg::CNT_W-1:0] occ_q;
	logic                      busy_q;
	logic                      rsp_valid_q;

	kot_pkg::op_t                  op_s1;
	logic [kot_pkg::KEY_BITS-1:0]  key_s1;
	logic [kot_pkg::CODE_W-1:0]    st_s1;
	logic [N-1:0]                  match_s1;

	logic                          hit_q;
	logic [kot_pkg::CODE_W-1:0]    status_q;
	logic [kot_pkg::OUT_W-1:0]     pos_q;
	logic [kot_pkg::OUT_W-1:0]     count_q;
	logic                          dropped_q;

	logic [kot_pkg::KEY_BITS-1:0]  cmp_key;
	logic [N-1:0]                  match;
	logic [kot_pkg::KEY_BITS-1:0]  cell_key [N+1];
	logic [kot_pkg::CODE_W-1:0]    cell_code [N+1];
	kot_pkg::cell_ctrl_t           ctrl [N];

	logic [N-1:0]                  mm1;
	logic [N-1:0]                  first;
	logic [N-1:0]                  upto;
	logic                          hit;
	logic                          full;
	logic [kot_pkg::IDX_W-1:0]     idx;
	logic [kot_pkg::CODE_W-1:0]    hit_code;
	logic [kot_pkg::CNT_W-1:0]     occ_next;
	logic [kot_pkg::CNT_W-1:0]     pos_wide;
	logic                          accept;

	assign cmp_key = req.key[kot_pkg::KEY_BITS-1:0];
	assign req.ready = !busy_q && (!rsp_valid_q || rsp.ready);
	assign accept = req.valid && req.ready;

	assign mm1   = match_s1 - N'(1);
	assign first = match_s1 & ~mm1;
	assign upto  = match_s1 ^ mm1;
	assign hit   = |match_s1;
	assign full  = (occ_q == kot_pkg::CNT_W'(N));

	always_comb begin
		idx      = '0;
		hit_code = '0;
		for (int i = 0; i < N; i++) begin
			idx      = idx | (first[i] ? kot_pkg::IDX_W'(i) : '0);
			hit_code = hit_code | (first[i] ? cell_code[i] : '0);
		end
	end

	assign pos_wide = kot_pkg::CNT_W'(idx) + kot_pkg::CNT_W'(1);

	always_comb begin
		occ_next = occ_q;
		unique case (op_s1)
			kot_pkg::OP_ADD: begin
				if (!full)
					occ_next = occ_q + kot_pkg::CNT_W'(1);
			end
			kot_pkg::OP_REMOVE: begin
				if (hit)
					occ_next = occ_q - kot_pkg::CNT_W'(1);
			end
			default: occ_next = occ_q;
		endcase
	end

	assign cell_key[N]  = '0;
	assign cell_code[N] = '0;

	for (genvar g = 0; g < N; g++) begin : g_cell
		logic occupied;
		assign occupied = (occ_q > kot_pkg::CNT_W'(g));

		always_comb begin
			ctrl[g].append   = busy_q && (op_s1 == kot_pkg::OP_ADD)
				&& (occ_q == kot_pkg::CNT_W'(g));
			ctrl[g].shift    = busy_q && (op_s1 == kot_pkg::OP_REMOVE) && hit
				&& (!upto[g] || first[g]);
			ctrl[g].set_code = busy_q && (op_s1 == kot_pkg::OP_UPDATE) && first[g];
			ctrl[g].key      = key_s1;
			ctrl[g].code     = (op_s1 == kot_pkg::OP_UPDATE) ? st_s1 : kot_pkg::CODE_RUNNING;
		end

		kot_cell u_cell (
			.clk       (clk),
			.cmp_key   (cmp_key),
			.occupied  (occupied),
			.ctrl      (ctrl[g]),
			.next_key  (cell_key[g+1]),
			.next_code (cell_code[g+1]),
			.key       (cell_key[g]),
			.code      (cell_code[g]),
			.match     (match[g])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= kot_pkg::op_t'(req.operation);
			key_s1   <= cmp_key;
			st_s1    <= req.new_status;
			match_s1 <= match;
		end
		if (busy_q) begin
			hit_q     <= hit;
			status_q  <= !hit ? '0 : (op_s1 == kot_pkg::OP_UPDATE) ? st_s1 : hit_code;
			pos_q     <= hit ? kot_pkg::OUT_W'(pos_wide) : '0;
			count_q   <= kot_pkg::OUT_W'(occ_next);
			dropped_q <= (op_s1 == kot_pkg::OP_ADD) && full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			busy_q <= accept;
			if (busy_q) begin
				occ_q       <= occ_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.hit          = hit_q;
	assign rsp.entry_status = status_q;
	assign rsp.position     = pos_q;
	assign rsp.entry_count  = count_q;
	assign rsp.add_dropped  = dropped_q;

endmodule

@@ tb/keyed_ordered_entry_table_top_tb.sv @@
// Testbench for the keyed ordered entry table: directed, fill, stall, sender pause and random request tests.
module keyed_ordered_entry_table_top_tb;
	import kot_pkg::*;

	localparam logic [CODE_W-1:0] CODE_STOPPED = 2'd1;
	localparam logic [CODE_W-1:0] CODE_RSVD_2 = 2'd2;
	localparam logic [CODE_W-1:0] CODE_RSVD_3 = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_REQUESTS = 1650;
	localparam int POOL_N = 12;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic              hit;
		logic [CODE_W-1:0] status;
		logic [OUT_W-1:0]  position;
		logic [OUT_W-1:0]  count;
		logic              dropped;
	} table_reply_t;

	logic clk;
	logic arst_n;

	kot_req_if req ();
	kot_rsp_if rsp ();

	keyed_ordered_entry_table_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// shadow copy of the table
	logic [KEY_BITS-1:0] tbl_key [DEPTH];
	logic [CODE_W-1:0]   tbl_code [DEPTH];
	int                  tbl_count;

	table_reply_t           expected_replies [$];
	logic [KEY_FIELD_W-1:0] key_pool [POOL_N];
	int                     fail_count;
	int                     cycle_count;
	int                     hold_off_len;
	bit                     idling_on;
	bit                     req_held;
	bit                     growing;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idling_on || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic table_reply_t apply_to_table(op_t op, logic [KEY_FIELD_W-1:0] key_in,
			logic [CODE_W-1:0] st);
		table_reply_t r;
		logic [KEY_BITS-1:0] k;
		int idx;
		k = key_in[KEY_BITS-1:0];
		idx = -1;
		r = '0;
		for (int i = 0; i < tbl_count; i++)
			if (idx < 0 && tbl_key[i] == k)
				idx = i;
		if (idx >= 0) begin
			r.hit = 1'b1;
			r.status = tbl_code[idx];
			r.position = OUT_W'(idx + 1);
		end
		case (op)
			OP_ADD: begin
				if (tbl_count >= DEPTH) begin
					r.dropped = 1'b1;
				end else begin
					tbl_key[tbl_count] = k;
					tbl_code[tbl_count] = CODE_RUNNING;
					tbl_count++;
				end
			end
			OP_UPDATE: begin
				if (idx >= 0) begin
					tbl_code[idx] = st;
					r.status = st;
				end
			end
			OP_REMOVE: begin
				if (idx >= 0) begin
					for (int i = idx; i + 1 < tbl_count; i++) begin
						tbl_key[i] = tbl_key[i + 1];
						tbl_code[i] = tbl_code[i + 1];
					end
					tbl_count--;
				end
			end
			default: begin
			end
		endcase
		r.count = OUT_W'(tbl_count);
		return r;
	endfunction

	function automatic logic [KEY_FIELD_W-1:0] choose_key(bit for_add);
		int r;
		r = $urandom_range(0, 99);
		if (tbl_count > 0 && r < (for_add ? 20 : 75))
			return tbl_key[$urandom_range(0, tbl_count - 1)];
		if (r < (for_add ? 50 : 90))
			return key_pool[$urandom_range(0, POOL_N - 1)];
		return KEY_FIELD_W'($urandom);
	endfunction

	task automatic send_request(op_t op, logic [KEY_FIELD_W-1:0] k, logic [CODE_W-1:0] st);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			if (req_held)
				req.valid <= 1'b0;
			req_held = 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= op;
		req.key <= k;
		req.new_status <= st;
		do
			@(posedge clk);
		while (!req.ready);
		expected_replies.push_back(apply_to_table(op, k, st));
		req_held = 1'b1;
	endtask

	task automatic wait_for_drain();
		if (req_held)
			req.valid <= 1'b0;
		req_held = 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
	endtask

	// one request; op mix leans toward filling or emptying the table
	task automatic random_request();
		int r;
		op_t op;
		r = $urandom_range(0, 99);
		if (growing)
			op = (r < 60) ? OP_ADD : (r < 75) ? OP_UPDATE : (r < 85) ? OP_REMOVE : OP_FIND;
		else
			op = (r < 15) ? OP_ADD : (r < 30) ? OP_UPDATE : (r < 80) ? OP_REMOVE : OP_FIND;
		send_request(op, choose_key(op == OP_ADD), CODE_W'($urandom_range(0, 3)));
		if (growing && tbl_count == DEPTH && $urandom_range(0, 3) == 0)
			growing = 1'b0;
		else if (!growing && tbl_count == 0)
			growing = 1'b1;
	endtask

	task automatic test_directed();
		idling_on = 1'b0;
		send_request(OP_FIND, '0, CODE_RSVD_3);
		send_request(OP_REMOVE, '0, CODE_RUNNING);
		send_request(OP_UPDATE, '0, CODE_STOPPED);
		send_request(OP_ADD, '0, CODE_RSVD_2);
		send_request(OP_ADD, '1, CODE_RSVD_3);
		send_request(OP_ADD, '0, CODE_RUNNING);
		send_request(OP_FIND, '0, CODE_STOPPED);
		send_request(OP_UPDATE, '1, CODE_RSVD_3);
		send_request(OP_UPDATE, '0, CODE_STOPPED);
		send_request(OP_FIND, '0, CODE_RUNNING);
		send_request(OP_ADD, 22'h2AAAAA, CODE_RSVD_2);
		send_request(OP_REMOVE, '0, CODE_RSVD_3);
		send_request(OP_FIND, '0, CODE_RSVD_2);
		send_request(OP_UPDATE, 22'h155555, CODE_RSVD_2);
		send_request(OP_FIND, '1, CODE_RUNNING);
		send_request(OP_UPDATE, 22'h2AAAAA, CODE_RSVD_2);
		send_request(OP_REMOVE, 22'h2AAAAA, CODE_RUNNING);
		send_request(OP_REMOVE, '1, CODE_STOPPED);
		send_request(OP_REMOVE, '0, CODE_RUNNING);
		send_request(OP_FIND, 22'h155555, CODE_RSVD_3);
		wait_for_drain();
	endtask

	task automatic test_fill_and_overflow();
		logic [KEY_FIELD_W-1:0] last_key;
		idling_on = 1'b1;
		last_key = '0;
		while (tbl_count < DEPTH) begin
			last_key = KEY_FIELD_W'($urandom);
			send_request(OP_ADD, last_key, CODE_W'($urandom_range(0, 3)));
		end
		repeat (3) send_request(OP_ADD, choose_key(1'b1), CODE_RUNNING);
		send_request(OP_FIND, last_key, CODE_RSVD_2);
		send_request(OP_UPDATE, last_key, CODE_RSVD_3);
		send_request(OP_REMOVE, tbl_key[DEPTH / 2], CODE_RUNNING);
		send_request(OP_ADD, last_key, CODE_STOPPED);
		send_request(OP_ADD, key_pool[0], CODE_RUNNING);
		send_request(OP_FIND, last_key, CODE_RUNNING);
		send_request(OP_REMOVE, tbl_key[DEPTH - 1], CODE_RUNNING);
		send_request(OP_REMOVE, tbl_key[0], CODE_RUNNING);
		growing = 1'b0;
	endtask

	// receiver stalls long; sender keeps offering until the input backs up
	task automatic test_output_stall();
		hold_off_len = 300;
		repeat (40) random_request();
	endtask

	task automatic test_sender_pause();
		repeat (20) random_request();
		wait_for_drain();
		repeat ($urandom_range(5, 30)) @(posedge clk);
		repeat (20) random_request();
	endtask

	task automatic test_random();
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 200 == 0)
				idling_on = ($urandom_range(0, 3) != 0);
			random_request();
		end
	endtask

	initial begin : receiver
		int stall;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_len > 0) begin
				stall = hold_off_len;
				hold_off_len = 0;
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
				rsp.ready <= 1'b1;
			end else begin
				stall = pick_gap();
				if (stall == 0) begin
					rsp.ready <= 1'b1;
				end else begin
					rsp.ready <= 1'b0;
					repeat (stall) @(posedge clk);
					rsp.ready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		table_reply_t exp;
		table_reply_t got;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = '{rsp.hit, rsp.entry_status, rsp.position, rsp.entry_count, rsp.add_dropped};
			if (expected_replies.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected response: hit=%0b status=%0d pos=%0d count=%0d drop=%0b",
						got.hit, got.status, got.position, got.count, got.dropped);
			end else begin
				exp = expected_replies.pop_front();
				if (got.hit !== exp.hit || got.status !== exp.status ||
						got.position !== exp.position || got.count !== exp.count ||
						got.dropped !== exp.dropped) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS) begin
						$display("mismatch: exp hit=%0b status=%0d pos=%0d count=%0d drop=%0b",
							exp.hit, exp.status, exp.position, exp.count, exp.dropped);
						$display("          got hit=%0b status=%0d pos=%0d count=%0d drop=%0b",
							got.hit, got.status, got.position, got.count, got.dropped);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.operation = OP_ADD;
		req.key = '0;
		req.new_status = CODE_RUNNING;
		fail_count = 0;
		cycle_count = 0;
		hold_off_len = 0;
		idling_on = 1'b0;
		req_held = 1'b0;
		growing = 1'b1;
		tbl_count = 0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_N; i++)
			key_pool[i] = KEY_FIELD_W'($urandom);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_and_overflow();
		test_output_stall();
		test_sender_pause();
		test_random();

		wait_for_drain();
		repeat (8) @(posedge clk);
		fail_count += expected_replies.size();
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
